FILE: src/ptsc_pkg.sv
// ----------------------------------------------------------------------------
// ptsc_pkg
// Shared types and constants for the pose to servo command block.
// ----------------------------------------------------------------------------
package ptsc_pkg;

  // Angle fixed point and servo position width
  localparam int ANGLE_FRAC_BITS = 4;
  localparam int POS_W           = 12;

  // Default depth of the pose queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Clamp limits in angle units
  localparam int FLEX_HALF  = 90 << ANGLE_FRAC_BITS;
  localparam int ROLL_HALF  = 180 << ANGLE_FRAC_BITS;
  localparam int UPPER_LO   = 40 << ANGLE_FRAC_BITS;
  localparam int UPPER_HI   = 110 << ANGLE_FRAC_BITS;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SPEED_WORD   = 2'd0,
    CFG_ACCEL_BYTE   = 2'd1,
    CFG_YAW_DEADBAND = 2'd2,
    CFG_MAX_STEP     = 2'd3
  } cfg_idx_e;

  // Configuration register file contents
  typedef struct packed {
    logic [15:0] speed_word;
    logic [7:0]  accel_byte;
    logic [7:0]  yaw_deadband;
    logic [11:0] max_step;
  } cfg_t;

  // One pose worth of finished positions
  typedef struct packed {
    logic [POS_W-1:0] flex_goal;
    logic [POS_W-1:0] roll_goal;
    logic [POS_W-1:0] pan_pos;
    logic [POS_W-1:0] lift_pos;
    logic [POS_W-1:0] elbow_pos;
    logic             pan_en;
    logic             grip_en;
    logic             grip_closed;
  } pose_cmd_t;

  // Command slots in emission order
  typedef enum logic [2:0] {
    STEP_FLEX,
    STEP_ROLL,
    STEP_PAN,
    STEP_LIFT,
    STEP_ELBOW,
    STEP_GRIP
  } step_e;

  // Servo numbers
  localparam logic [2:0] SERVO_PAN   = 3'd1;
  localparam logic [2:0] SERVO_LIFT  = 3'd2;
  localparam logic [2:0] SERVO_ELBOW = 3'd3;
  localparam logic [2:0] SERVO_FLEX  = 3'd4;
  localparam logic [2:0] SERVO_ROLL  = 3'd5;
  localparam logic [2:0] SERVO_GRIP  = 3'd6;

  // Gripper goal positions
  localparam logic [POS_W-1:0] GRIP_CLOSED_POS = POS_W'(3504);
  localparam logic [POS_W-1:0] GRIP_OPEN_POS   = POS_W'(2090);

endpackage

FILE: src/ptsc_front.sv
// ----------------------------------------------------------------------------
// ptsc_front
// Pose intake: clamps, scales and slew-limits the joints of each pose and
// writes one finished position record per pose into the queue.
// ----------------------------------------------------------------------------
module ptsc_front import ptsc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] roll_ang_i,
  input  logic signed [15:0] pitch_ang_i,
  input  logic signed [15:0] yaw_ang_i,
  input  logic signed [15:0] shoulder_ang_i,
  input  logic               gripper_present_i,
  input  logic               grip_shut_i,
  input  cfg_t               cfg_i,
  input  logic [CntW-1:0]    q_count_i,
  output logic               q_push_o,
  output pose_cmd_t          q_data_o
);

  localparam logic signed [15:0] PitchLo = 16'(-FLEX_HALF);
  localparam logic signed [15:0] PitchHi = 16'(FLEX_HALF);
  localparam logic signed [15:0] RollLo  = 16'(-ROLL_HALF);
  localparam logic signed [15:0] RollHi  = 16'(ROLL_HALF);
  localparam logic signed [15:0] UpLo    = 16'(-UPPER_LO);
  localparam logic signed [15:0] UpHi    = 16'(UPPER_HI);

  logic accept;

  // stage A registers
  logic               a_valid_q;
  logic [18:0]        a_flex_q;
  logic [22:0]        a_roll_q;
  logic signed [31:0] a_pan_q;
  logic [24:0]        a_up_q;
  logic               a_pan_en_q, a_grip_en_q, a_grip_cl_q;

  // stage B registers
  logic               b_valid_q;
  logic [POS_W-1:0]   b_flex_q, b_roll_q;
  logic [11:0]        b_pan_q;
  logic               b_pan_neg_q, b_pan_hi_q;
  logic [10:0]        b_upq_q;
  logic [24:0]        b_up_q;
  logic               b_pan_en_q, b_grip_en_q, b_grip_cl_q;

  // joint state
  logic               zero_valid_q;
  logic signed [15:0] zero_q;
  logic [POS_W-1:0]   lift_q, lift_d, elbow_q, elbow_d;

  // hold off intake while queue space is promised to items in flight
  logic [CntW:0] promised;
  assign promised = {1'b0, q_count_i} + (CntW+1)'(a_valid_q) + (CntW+1)'(b_valid_q);
  assign full     = promised >= (CntW+1)'(QUEUE_DEPTH);
  assign accept   = push && !full;

  // ---------------- stage A: clamp and first products ----------------
  logic signed [15:0] pitch_c, roll_c, up_c;
  logic [11:0]        x_flex, x_up;
  logic [12:0]        x_roll;
  logic signed [16:0] pan_d, pan_dz, db;
  logic [18:0]        flex_prod;
  logic [22:0]        roll_prod;
  logic signed [31:0] pan_prod;
  logic [24:0]        up_prod;

  always_comb begin
    pitch_c = pitch_ang_i;
    if (pitch_ang_i < PitchLo) pitch_c = PitchLo;
    else if (pitch_ang_i > PitchHi) pitch_c = PitchHi;
    roll_c = roll_ang_i;
    if (roll_ang_i < RollLo) roll_c = RollLo;
    else if (roll_ang_i > RollHi) roll_c = RollHi;
    up_c = shoulder_ang_i;
    if (shoulder_ang_i < UpLo) up_c = UpLo;
    else if (shoulder_ang_i > UpHi) up_c = UpHi;

    x_flex = 12'(pitch_c - PitchLo);
    x_roll = 13'(roll_c - RollLo);
    x_up   = 12'(up_c - UpLo);

    // flex scale is 1995/2880 = 133/192, roll scale 3995/5760 = 799/1152
    flex_prod = 19'(x_flex) * 19'd133;
    roll_prod = 23'(x_roll) * 23'd799;
    up_prod   = 25'(x_up) * 25'd11378;

    // yaw offset with deadband
    pan_d  = $signed({yaw_ang_i[15], yaw_ang_i}) - $signed({zero_q[15], zero_q});
    db     = $signed({9'b0, cfg_i.yaw_deadband});
    pan_dz = (pan_d > -db && pan_d < db) ? 17'sd0 : pan_d;
    pan_prod = $signed({{15{pan_dz[16]}}, pan_dz}) * 32'sd11378;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q    <= 1'b0;
      zero_valid_q <= 1'b0;
      zero_q       <= '0;
    end else begin
      a_valid_q <= accept;
      // capture the yaw zero from the first pose
      if (accept && !zero_valid_q) begin
        zero_valid_q <= 1'b1;
        zero_q       <= yaw_ang_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_flex_q    <= flex_prod;
      a_roll_q    <= roll_prod;
      a_pan_q     <= pan_prod;
      a_up_q      <= up_prod;
      a_pan_en_q  <= zero_valid_q;
      a_grip_en_q <= gripper_present_i;
      a_grip_cl_q <= grip_shut_i;
    end
  end

  // ---------------- stage B: reciprocal divides ----------------
  logic [28:0]        flex_m;
  logic [34:0]        roll_m;
  logic signed [31:0] pan_n;
  logic [38:0]        pan_m;
  logic [37:0]        up_m;

  always_comb begin
    // floor(z/3) and floor(z/9) by reciprocal
    flex_m = 29'(a_flex_q[18:6]) * 29'd43691;
    roll_m = 35'(a_roll_q[22:7]) * 35'd58255;
    // pan numerator over 16000: only the range below the upper clamp is divided
    pan_n  = a_pan_q + 32'sd32752000;
    pan_m  = 39'(pan_n[25:7]) * 39'd536871;
    up_m   = 38'(a_up_q[24:7]) * 38'd536871;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      b_flex_q    <= 12'd2100 + 12'(flex_m[28:17]);
      b_roll_q    <= 12'd100 + 12'(roll_m[34:19]);
      b_pan_q     <= 12'(pan_m[38:26]);
      b_pan_neg_q <= pan_n[31];
      b_pan_hi_q  <= pan_n >= 32'sd46416000;
      b_upq_q     <= up_m[36:26];
      b_up_q      <= a_up_q;
      b_pan_en_q  <= a_pan_en_q;
      b_grip_en_q <= a_grip_en_q;
      b_grip_cl_q <= a_grip_cl_q;
    end
  end

  // ---------------- stage C: clamp, slew, write queue ----------------
  function automatic logic [POS_W-1:0] slew(input logic [POS_W-1:0] cur,
                                            input logic [POS_W-1:0] tgt,
                                            input logic [11:0] ms);
    logic [POS_W:0] diff;
    if (tgt >= cur) begin
      diff = {1'b0, tgt} - {1'b0, cur};
      slew = (diff > (POS_W+1)'(ms)) ? POS_W'(cur + POS_W'(ms)) : tgt;
    end else begin
      diff = {1'b0, cur} - {1'b0, tgt};
      slew = (diff > (POS_W+1)'(ms)) ? POS_W'(cur - POS_W'(ms)) : tgt;
    end
  endfunction

  logic [POS_W-1:0] pan_pos, lift_t, elbow_t, elbow_c;
  logic [24:0]      up_back;

  always_comb begin
    if (b_pan_neg_q)              pan_pos = 12'd1000;
    else if (b_pan_hi_q)          pan_pos = 12'd2900;
    else if (b_pan_q < 12'd1000)  pan_pos = 12'd1000;
    else                          pan_pos = b_pan_q;

    lift_t = 12'd2050 + 12'(b_upq_q);
    if (lift_t > 12'd3800) lift_t = 12'd3800;
    else if (lift_t < 12'd2025) lift_t = 12'd2025;

    // elbow subtracts, so round the quotient up when a remainder is left
    up_back = (25'(b_upq_q) << 14) - (25'(b_upq_q) << 8) - (25'(b_upq_q) << 7);
    elbow_c = 12'(b_upq_q) + 12'(up_back != b_up_q);
    elbow_t = 12'd2052 - elbow_c;
    if (elbow_t > 12'd3895) elbow_t = 12'd3895;
    else if (elbow_t < 12'd300) elbow_t = 12'd300;

    lift_d  = slew(lift_q, lift_t, cfg_i.max_step);
    elbow_d = slew(elbow_q, elbow_t, cfg_i.max_step);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lift_q  <= POS_W'(2050);
      elbow_q <= POS_W'(2052);
    end else if (b_valid_q) begin
      lift_q  <= lift_d;
      elbow_q <= elbow_d;
    end
  end

  assign q_push_o = b_valid_q;
  always_comb begin
    q_data_o.flex_goal   = b_flex_q;
    q_data_o.roll_goal   = b_roll_q;
    q_data_o.pan_pos     = pan_pos;
    q_data_o.lift_pos    = lift_d;
    q_data_o.elbow_pos   = elbow_d;
    q_data_o.pan_en      = b_pan_en_q;
    q_data_o.grip_en     = b_grip_en_q;
    q_data_o.grip_closed = b_grip_cl_q;
  end

endmodule

FILE: src/ptsc_fifo.sv
// ----------------------------------------------------------------------------
// ptsc_fifo
// Short queue of pose records between the front and the back.
// ----------------------------------------------------------------------------
module ptsc_fifo import ptsc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int CntW = $clog2(QUEUE_DEPTH + 1),
  localparam int PtrW = $clog2(QUEUE_DEPTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pose_cmd_t       data_i,
  input  logic            pop_i,
  output logic            nonempty_o,
  output pose_cmd_t       head_o,
  output logic [CntW-1:0] count_o
);

  pose_cmd_t       mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    bump = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  // advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= bump(wptr_q);
      if (pop_i)  rptr_q <= bump(rptr_q);
      count_q <= count_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  assign head_o     = mem_q[rptr_q];
  assign nonempty_o = count_q != '0;
  assign count_o    = count_q;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != CntW'(QUEUE_DEPTH) || pop_i))
    else $error("pose queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pose queue underflow");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("pose queue count out of range");
`endif

endmodule

FILE: src/ptsc_back.sv
// ----------------------------------------------------------------------------
// ptsc_back
// Command sequencer: walks each queued pose through its servo commands,
// one word a cycle while the receiver keeps popping, into the result register.
// ----------------------------------------------------------------------------
module ptsc_back import ptsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_nonempty_i,
  input  pose_cmd_t        q_head_i,
  output logic             q_pop_o,
  input  cfg_t             cfg_i,
  output logic             empty,
  input  logic             pop,
  output logic [2:0]       servo_id_o,
  output logic [POS_W-1:0] position_o,
  output logic [15:0]      speed_o,
  output logic [7:0]       accel_o,
  output logic [7:0]       checksum_o,
  output logic             last_packet_o
);

  step_e            step_q, step_d;
  logic             fire;
  logic [2:0]       cmd_id;
  logic [POS_W-1:0] cmd_pos;
  logic             cmd_last;

  logic             out_valid_q;

  function automatic logic [7:0] csum(input logic [2:0] id, input logic [POS_W-1:0] p,
                                      input logic [15:0] s, input logic [7:0] a);
    logic [7:0] sum;
    sum = 8'(id) + 8'h0A + 8'h03 + 8'h29 + a + p[7:0] + 8'(p[POS_W-1:8])
        + s[7:0] + s[15:8];
    csum = ~sum;
  endfunction

  // emit when a pose waits and the result slot frees up
  assign fire = q_nonempty_i && (!out_valid_q || pop);

  // next step
  always_comb begin
    step_d = step_q;
    if (fire) begin
      unique case (step_q)
        STEP_FLEX:  step_d = STEP_ROLL;
        STEP_ROLL:  step_d = q_head_i.pan_en ? STEP_PAN : STEP_LIFT;
        STEP_PAN:   step_d = STEP_LIFT;
        STEP_LIFT:  step_d = STEP_ELBOW;
        STEP_ELBOW: step_d = q_head_i.grip_en ? STEP_GRIP : STEP_FLEX;
        STEP_GRIP:  step_d = STEP_FLEX;
        default:    step_d = STEP_FLEX;
      endcase
    end
  end

  // command of the current step
  always_comb begin
    cmd_last = 1'b0;
    unique case (step_q)
      STEP_FLEX: begin
        cmd_id  = SERVO_FLEX;
        cmd_pos = q_head_i.flex_goal;
      end
      STEP_ROLL: begin
        cmd_id  = SERVO_ROLL;
        cmd_pos = q_head_i.roll_goal;
      end
      STEP_PAN: begin
        cmd_id  = SERVO_PAN;
        cmd_pos = q_head_i.pan_pos;
      end
      STEP_LIFT: begin
        cmd_id  = SERVO_LIFT;
        cmd_pos = q_head_i.lift_pos;
      end
      STEP_ELBOW: begin
        cmd_id   = SERVO_ELBOW;
        cmd_pos  = q_head_i.elbow_pos;
        cmd_last = !q_head_i.grip_en;
      end
      STEP_GRIP: begin
        cmd_id   = SERVO_GRIP;
        cmd_pos  = q_head_i.grip_closed ? GRIP_CLOSED_POS : GRIP_OPEN_POS;
        cmd_last = 1'b1;
      end
      default: begin
        cmd_id  = SERVO_FLEX;
        cmd_pos = q_head_i.flex_goal;
      end
    endcase
  end

  assign q_pop_o = fire && cmd_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_FLEX;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= fire || (out_valid_q && !pop);
    end
  end

  // load the result word
  always_ff @(posedge clk_i) begin
    if (fire) begin
      servo_id_o    <= cmd_id;
      position_o    <= cmd_pos;
      speed_o       <= cfg_i.speed_word;
      accel_o       <= cfg_i.accel_byte;
      checksum_o    <= csum(cmd_id, cmd_pos, cfg_i.speed_word, cfg_i.accel_byte);
      last_packet_o <= cmd_last;
    end
  end

  assign empty = !out_valid_q;

endmodule

FILE: src/pose_to_servo_command_packets_core.sv
// ----------------------------------------------------------------------------
// pose_to_servo_command_packets_core
// Turns arm poses into servo write command words with checksums.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  pose in  | push / full      | roll_ang, pitch_ang, yaw_ang, shoulder_ang,
//           |                  | gripper_present, grip_shut
//  word out | empty / pop      | servo_id, position, speed, accel, checksum,
//           |                  | last_packet
//  config   | cfg_we_i         | cfg_index_i, cfg_data_i
//
// A pose passes through front pipeline stages A and B into the pose queue;
// the sequencer then emits its 4 to 6 words one per cycle through the single
// result register while pop keeps taking them. Full rises when the pose
// queue plus the poses in the front pipeline reach QUEUE_DEPTH. A stalled pop
// holds the word and backs up the queue; intake continues until the queue is
// promised out. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module pose_to_servo_command_packets_core import ptsc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] roll_ang_i,
  input  logic signed [15:0] pitch_ang_i,
  input  logic signed [15:0] yaw_ang_i,
  input  logic signed [15:0] shoulder_ang_i,
  input  logic               gripper_present_i,
  input  logic               grip_shut_i,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         servo_id_o,
  output logic [POS_W-1:0]   position_o,
  output logic [15:0]        speed_o,
  output logic [7:0]         accel_o,
  output logic [7:0]         checksum_o,
  output logic               last_packet_o
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cfg_t            cfg_q;
  logic            q_push, q_pop, q_nonempty;
  pose_cmd_t       q_wdata, q_head;
  logic [CntW-1:0] q_count;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_word   <= 16'd200;
      cfg_q.accel_byte   <= 8'd20;
      cfg_q.yaw_deadband <= 8'd8;
      cfg_q.max_step     <= 12'd40;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SPEED_WORD:   cfg_q.speed_word   <= cfg_data_i;
        CFG_ACCEL_BYTE:   cfg_q.accel_byte   <= cfg_data_i[7:0];
        CFG_YAW_DEADBAND: cfg_q.yaw_deadband <= cfg_data_i[7:0];
        CFG_MAX_STEP:     cfg_q.max_step     <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  ptsc_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .roll_ang_i,
    .pitch_ang_i,
    .yaw_ang_i,
    .shoulder_ang_i,
    .gripper_present_i,
    .grip_shut_i,
    .cfg_i     (cfg_q),
    .q_count_i (q_count),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  ptsc_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i     (q_push),
    .data_i     (q_wdata),
    .pop_i      (q_pop),
    .nonempty_o (q_nonempty),
    .head_o     (q_head),
    .count_o    (q_count)
  );

  ptsc_back u_back (
    .clk_i,
    .rst_ni,
    .q_nonempty_i (q_nonempty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .cfg_i        (cfg_q),
    .empty,
    .pop,
    .servo_id_o,
    .position_o,
    .speed_o,
    .accel_o,
    .checksum_o,
    .last_packet_o
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives arm poses into the pose to servo command block and checks every
// command word against a predictor kept in step with the register settings.
// A short table of directed poses is followed by random poses in several
// register phases, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import ptsc_pkg::*;

  localparam longint CYCLE_LIMIT = 1_000_000;
  localparam int     CPD_NUM     = 11378;
  localparam int     CPD_DEN     = 1000;
  localparam int     ANG_ONE     = 1 << ANGLE_FRAC_BITS;
  localparam int     PAN_MID     = 2047;
  localparam int     LIFT_MID    = 2050;
  localparam int     ELBOW_MID   = 2052;
  localparam logic [7:0] HDR_LEN   = 8'h0A;
  localparam logic [7:0] HDR_WRITE = 8'h03;
  localparam logic [7:0] HDR_ADDR  = 8'h29;

  typedef struct packed {
    logic [2:0]  id;
    logic [11:0] pos;
    logic [15:0] speed;
    logic [7:0]  accel;
    logic [7:0]  chk;
    logic        last;
  } word_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] upper;
    bit gp;
    bit gc;
    int flex_exp;
    int roll_exp;
  } pose_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  logic signed [15:0] roll_ang_i = '0, pitch_ang_i = '0;
  logic signed [15:0] yaw_ang_i = '0, shoulder_ang_i = '0;
  logic gripper_present_i = 1'b0, grip_shut_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] servo_id_o;
  logic [POS_W-1:0] position_o;
  logic [15:0] speed_o;
  logic [7:0] accel_o, checksum_o;
  logic last_packet_o;

  pose_to_servo_command_packets_core uut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state and register copies
  logic [15:0] speed_reg;
  logic [7:0]  accel_reg, deadband_reg;
  logic [11:0] step_reg;
  logic [11:0] lift_now, elbow_now;
  bit          zero_ok;
  longint      zero_angle;

  word_t  pending_words[$];
  int     errors = 0;
  int     words_seen = 0;
  int     poses_sent = 0;
  int     send_idle = 0;
  int     recv_idle = 0;
  int     hold_req = 0;
  longint cycles = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic longint clip(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic word_t make_word(logic [2:0] id, longint p);
    word_t w;
    logic [7:0] sum;
    w.id    = id;
    w.pos   = 12'(p);
    w.speed = speed_reg;
    w.accel = accel_reg;
    w.last  = 1'b0;
    sum = 8'(id) + HDR_LEN + HDR_WRITE + HDR_ADDR + accel_reg + w.pos[7:0]
        + 8'(w.pos[11:8]) + speed_reg[7:0] + speed_reg[15:8];
    w.chk = ~sum;
    return w;
  endfunction

  function automatic logic [11:0] slew_to(logic [11:0] cur, longint tgt);
    longint d;
    d = clip(tgt - longint'(cur), -longint'(step_reg), longint'(step_reg));
    return 12'(longint'(cur) + d);
  endfunction

  // Compute the command words of one pose and advance the predictor state
  task automatic predict_pose(input pose_row_t r, output int flex_calc,
                              output int roll_calc);
    word_t  words[$];
    longint a, d, e, t_lift, t_elbow;
    a = clip(r.pitch, -90 * ANG_ONE, 90 * ANG_ONE);
    flex_calc = 2100 + ((a + 90 * ANG_ONE) * 1995) / (180 * ANG_ONE);
    words.push_back(make_word(SERVO_FLEX, flex_calc));
    a = clip(r.roll, -180 * ANG_ONE, 180 * ANG_ONE);
    roll_calc = 100 + ((a + 180 * ANG_ONE) * 3995) / (360 * ANG_ONE);
    words.push_back(make_word(SERVO_ROLL, roll_calc));
    if (!zero_ok) begin
      zero_angle = r.yaw;
      zero_ok = 1;
    end else begin
      d = longint'(r.yaw) - zero_angle;
      if (d > -longint'(deadband_reg) && d < longint'(deadband_reg)) d = 0;
      words.push_back(make_word(SERVO_PAN, clip((PAN_MID * ANG_ONE * CPD_DEN
        + d * CPD_NUM) / (ANG_ONE * CPD_DEN), 1000, 2900)));
    end
    e = clip(r.upper, -40 * ANG_ONE, 110 * ANG_ONE) + 40 * ANG_ONE;
    t_lift  = clip((LIFT_MID * ANG_ONE * CPD_DEN + e * CPD_NUM) / (ANG_ONE * CPD_DEN),
                   2025, 3800);
    t_elbow = clip((ELBOW_MID * ANG_ONE * CPD_DEN - e * CPD_NUM) / (ANG_ONE * CPD_DEN),
                   300, 3895);
    lift_now  = slew_to(lift_now, t_lift);
    elbow_now = slew_to(elbow_now, t_elbow);
    words.push_back(make_word(SERVO_LIFT, lift_now));
    words.push_back(make_word(SERVO_ELBOW, elbow_now));
    if (r.gp) words.push_back(make_word(SERVO_GRIP,
                                        r.gc ? GRIP_CLOSED_POS : GRIP_OPEN_POS));
    words[words.size() - 1].last = 1'b1;
    foreach (words[i]) pending_words.push_back(words[i]);
  endtask

  // Offer one pose and hold it until the block takes it
  task automatic send_pose(input pose_row_t r);
    bit taken;
    int fp, rp;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push              <= 1'b1;
    roll_ang_i        <= r.roll;
    pitch_ang_i       <= r.pitch;
    yaw_ang_i         <= r.yaw;
    shoulder_ang_i    <= r.upper;
    gripper_present_i <= r.gp;
    grip_shut_i       <= r.gc;
    do begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
    end while (!taken);
    predict_pose(r, fp, rp);
    poses_sent++;
    if (r.flex_exp >= 0 && fp != r.flex_exp) report("directed flex", fp, r.flex_exp);
    if (r.roll_exp >= 0 && rp != r.roll_exp) report("directed roll", rp, r.roll_exp);
  endtask

  // Wait for all words out, then let the pipeline settle before a write
  task automatic drain();
    push <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Write one register; the caller drops the write enable after the last one
  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      CFG_SPEED_WORD:   speed_reg    = val;
      CFG_ACCEL_BYTE:   accel_reg    = val[7:0];
      CFG_YAW_DEADBAND: deadband_reg = val[7:0];
      CFG_MAX_STEP:     step_reg     = val[11:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] rand_angle(int span);
    if ($urandom_range(9) < 2) return 16'($urandom);
    return 16'($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic pose_row_t rand_pose();
    pose_row_t r;
    r.roll  = rand_angle(200 * ANG_ONE);
    r.pitch = rand_angle(100 * ANG_ONE);
    r.upper = rand_angle(120 * ANG_ONE);
    if ($urandom_range(3) == 0) r.yaw = 16'($urandom);
    else r.yaw = 16'(zero_angle + $signed($urandom_range(600)) - 300);
    r.gp = 1'($urandom_range(1));
    r.gc = 1'($urandom_range(1));
    r.flex_exp = -1;
    r.roll_exp = -1;
    return r;
  endfunction

  // Receiver: random pops with an optional long hold-off
  int hold_seen = 0;
  int hold_cnt = 0;
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt  <= 400;
      pop       <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      pop      <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Check each word that will be taken at the next edge
  always @(negedge clk_i) begin
    word_t w;
    if (rst_ni && pop && !empty) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        report("unexpected word, servo", servo_id_o, 0);
      end else begin
        w = pending_words.pop_front();
        if (servo_id_o != w.id) report("servo_id", servo_id_o, w.id);
        if (position_o != w.pos) report("position", position_o, w.pos);
        if (speed_o != w.speed) report("speed", speed_o, w.speed);
        if (accel_o != w.accel) report("accel", accel_o, w.accel);
        if (checksum_o != w.chk) report("checksum", checksum_o, w.chk);
        if (last_packet_o != w.last) report("last_packet", last_packet_o, w.last);
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Directed poses: first pose sets the yaw zero, then extremes and deadband edges
  pose_row_t dir_rows[18] = '{
    '{16'sd0,      16'sd0,      16'sd0,      16'sd0,      1'b0, 1'b0, 3097, 2097},
    '{-16'sd32768, -16'sd32768, 16'sd7,      -16'sd32768, 1'b1, 1'b0, 2100, 100},
    '{16'sd32767,  16'sd32767,  -16'sd7,     16'sd32767,  1'b1, 1'b1, 4095, 4095},
    '{16'sd2880,   16'sd1440,   16'sd8,      16'sd1760,   1'b0, 1'b1, 4095, 4095},
    '{-16'sd2880,  -16'sd1440,  -16'sd8,     -16'sd640,   1'b1, 1'b0, 2100, 100},
    '{16'sd1,      16'sd1,      16'sd32767,  16'sd1761,   1'b1, 1'b1, -1, -1},
    '{-16'sd1,     -16'sd1,     -16'sd32768, -16'sd641,   1'b0, 1'b0, -1, -1},
    '{16'sd2881,   16'sd1441,   16'sd1440,   16'sd100,    1'b1, 1'b0, 4095, 4095},
    '{-16'sd2881,  -16'sd1441,  -16'sd1440,  16'sd32767,  1'b1, 1'b1, 2100, 100},
    '{16'sd100,    16'sd200,    16'sd9,      16'sd32767,  1'b0, 1'b0, -1, -1},
    '{-16'sd100,   -16'sd200,   -16'sd9,     16'sd32767,  1'b0, 1'b1, -1, -1},
    '{16'sd0,      16'sd0,      16'sd0,      -16'sd32768, 1'b1, 1'b0, 3097, 2097},
    '{16'sd0,      16'sd0,      16'sd0,      -16'sd32768, 1'b1, 1'b1, 3097, 2097},
    '{16'sd0,      16'sd0,      16'sd0,      16'sd0,      1'b0, 1'b0, 3097, 2097},
    '{16'sd5,      -16'sd5,     16'sd2000,   16'sd500,    1'b1, 1'b0, -1, -1},
    '{-16'sd5,     16'sd5,      -16'sd2000,  16'sd500,    1'b1, 1'b1, -1, -1},
    '{16'sd4000,   -16'sd4000,  16'sd3000,   16'sd1000,   1'b0, 1'b0, 2100, 4095},
    '{-16'sd4000,  16'sd4000,   -16'sd3000,  16'sd1000,   1'b1, 1'b1, 4095, 100}
  };

  initial begin
    pose_row_t r;
    speed_reg = 16'd200;
    accel_reg = 8'd20;
    deadband_reg = 8'd8;
    step_reg = 12'd40;
    lift_now = 12'd2050;
    elbow_now = 12'd2052;
    zero_ok = 0;
    zero_angle = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings, light idling
    send_idle = 10;
    recv_idle = 30;
    foreach (dir_rows[i]) send_pose(dir_rows[i]);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_SPEED_WORD, 16'd0);
          write_reg(CFG_ACCEL_BYTE, 16'd0);
          write_reg(CFG_YAW_DEADBAND, 16'd0);
          write_reg(CFG_MAX_STEP, 16'd0);
        end
        1: begin
          write_reg(CFG_SPEED_WORD, 16'hFFFF);
          write_reg(CFG_ACCEL_BYTE, 16'hFFFF);
          write_reg(CFG_YAW_DEADBAND, 16'hFFFF);
          write_reg(CFG_MAX_STEP, 16'hFFFF);
        end
        default: begin
          write_reg(CFG_SPEED_WORD, 16'($urandom));
          write_reg(CFG_ACCEL_BYTE, 16'($urandom));
          write_reg(CFG_YAW_DEADBAND, 16'($urandom_range(64)));
          write_reg(CFG_MAX_STEP, 16'($urandom_range(300)));
        end
      endcase
      cfg_we_i <= 1'b0;
      send_idle = (ph < 2) ? 19 : ((ph < 4) ? 87 : 0);
      recv_idle = (ph < 2) ? 87 : ((ph < 4) ? 19 : 0);
      for (int k = 0; k < 77; k++) begin
        // Receiver stalls long while poses keep coming, so intake backs up
        if (ph == 2 && k == 10) begin
          send_idle = 0;
          hold_req++;
        end
        if (ph == 2 && k == 40) send_idle = 87;
        // Sender pauses until every word is out
        if (ph == 4 && k == 38) begin
          push <= 1'b0;
          wait (pending_words.size() == 0);
          @(posedge clk_i);
        end
        r = rand_pose();
        send_pose(r);
      end
    end

    push <= 1'b0;
    fork
      wait (pending_words.size() == 0);
    join
    repeat (40) @(posedge clk_i);
    if (pending_words.size() != 0) report("words left over", pending_words.size(), 0);

    $display("Sent %0d poses and checked %0d command words under six register settings,",
             poses_sent, words_seen);
    $display("including zero and full-scale registers, input back-pressure and drains.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
